### hdl/rsm_pkg.sv
// Shared types and constants for the range reverse / min-max table block.
// Used by rsm_mem, rsm_seq and range_reverse_min_max_table; no dependencies.
package rsm_pkg;

  localparam int unsigned ValW  = 16;
  localparam int unsigned IdxW  = 5;
  localparam int unsigned PosW  = 5;
  localparam int unsigned KindW = 2;

  // Result kinds.
  localparam logic [KindW-1:0] KIND_ELEM = 2'd0;
  localparam logic [KindW-1:0] KIND_SUM  = 2'd1;
  localparam logic [KindW-1:0] KIND_FULL = 2'd2;

  // Input functions.
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // Configuration register indexes and reset values.
  localparam logic CFG_MAX_FLOOR   = 1'b0;
  localparam logic CFG_MIN_CEILING = 1'b1;
  localparam logic signed [ValW-1:0] MAX_FLOOR_RST   = 16'sd0;
  localparam logic signed [ValW-1:0] MIN_CEILING_RST = 16'sd1000;

  typedef struct packed {
    logic                   func;
    logic signed [ValW-1:0] value;
    logic [IdxW-1:0]        start_index;
    logic [IdxW-1:0]        end_index;
  } in_word_t;

  typedef struct packed {
    logic [KindW-1:0]       kind;
    logic [PosW-1:0]        position;
    logic signed [ValW-1:0] element;
    logic signed [ValW-1:0] range_max;
    logic signed [ValW-1:0] range_min;
    logic                   last;
  } out_word_t;

  typedef struct packed {
    logic signed [ValW-1:0] max_floor;
    logic signed [ValW-1:0] min_ceiling;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SW_RD_LO,
    ST_SW_RD_HI,
    ST_SW_WR_LO,
    ST_SW_WR_HI,
    ST_SCAN_RD,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT,
    ST_SUM
  } state_e;

endpackage

### hdl/rsm_mem.sv
// Table storage: one synchronous read port and one write port; read data is registered.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses rsm_pkg.
module rsm_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic signed [rsm_pkg::ValW-1:0] wdata_i,
  output logic signed [rsm_pkg::ValW-1:0] rdata_o
);

  logic signed [rsm_pkg::ValW-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]                vld_q;
  logic signed [rsm_pkg::ValW-1:0] rdata_q;
  logic                            rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  // An entry never written since reset reads as zero.
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

### hdl/rsm_seq.sv
// Sequencer: appends, in-place range reversal, range scan, element and summary emission,
// all through the single-read-port table in rsm_mem. Holds the output register. Uses rsm_pkg.
module rsm_seq #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned CW    = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rsm_pkg::cfg_t                   cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rsm_pkg::in_word_t               in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rsm_pkg::out_word_t              out_word_o,
  output logic                            mem_re_o,
  output logic [AW-1:0]                   mem_raddr_o,
  output logic                            mem_we_o,
  output logic [AW-1:0]                   mem_waddr_o,
  output logic signed [rsm_pkg::ValW-1:0] mem_wdata_o,
  input  logic signed [rsm_pkg::ValW-1:0] mem_rdata_i
);

  rsm_pkg::state_e state_q, state_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]   s_q, s_d, e_q, e_d;
  logic [AW-1:0]   sc_q, sc_d;
  logic [AW-1:0]   pos_q, pos_d;
  logic signed [rsm_pkg::ValW-1:0] tmp_q, tmp_d;
  logic signed [rsm_pkg::ValW-1:0] mx_q, mx_d, mn_q, mn_d;
  logic                 out_valid_q, out_valid_d;
  rsm_pkg::out_word_t   out_q, out_d;

  logic          accept;
  logic          out_free;
  logic [31:0]   s_ext, e_ext, s_clamp, e_clamp;
  logic [AW-1:0] s_in, e_in;
  logic [AW-1:0] lo_n, hi_n;
  logic [CW-1:0] depth_cnt;

  assign depth_cnt  = CW'(DEPTH);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != rsm_pkg::ST_IDLE) || out_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  // Indexes at or beyond the table saturate to its last position.
  assign s_ext   = 32'(in_word_i.start_index);
  assign e_ext   = 32'(in_word_i.end_index);
  assign s_clamp = (s_ext >= 32'(DEPTH)) ? 32'(DEPTH - 1) : s_ext;
  assign e_clamp = (e_ext >= 32'(DEPTH)) ? 32'(DEPTH - 1) : e_ext;
  assign s_in    = s_clamp[AW-1:0];
  assign e_in    = e_clamp[AW-1:0];

  assign lo_n = lo_q + AW'(1);
  assign hi_n = hi_q - AW'(1);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    s_d         = s_q;
    e_d         = e_q;
    sc_d        = sc_q;
    pos_d       = pos_q;
    tmp_d       = tmp_q;
    mx_d        = mx_q;
    mn_d        = mn_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;

    unique case (state_q)
      rsm_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_word_i.func == rsm_pkg::FUNC_APPEND) begin
            if (fill_q == depth_cnt) begin
              out_valid_d = 1'b1;
              out_d       = '0;
              out_d.kind  = rsm_pkg::KIND_FULL;
              out_d.last  = 1'b1;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = fill_q[AW-1:0];
              mem_wdata_o = in_word_i.value;
              fill_d      = fill_q + CW'(1);
            end
          end else begin
            s_d   = s_in;
            e_d   = e_in;
            lo_d  = s_in;
            hi_d  = e_in;
            cnt_d = '0;
            mx_d  = cfg_i.max_floor;
            mn_d  = cfg_i.min_ceiling;
            if (s_in < e_in) begin
              state_d = rsm_pkg::ST_SW_RD_LO;
            end else if (s_in == e_in) begin
              state_d = rsm_pkg::ST_SCAN_RD;
            end else if (fill_q == '0) begin
              state_d = rsm_pkg::ST_SUM;
            end else begin
              state_d = rsm_pkg::ST_EMIT_RD;
            end
          end
        end
      end
      rsm_pkg::ST_SW_RD_LO: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = lo_q;
        state_d     = rsm_pkg::ST_SW_RD_HI;
      end
      rsm_pkg::ST_SW_RD_HI: begin
        // The low entry arrives now while the high entry is requested.
        tmp_d       = mem_rdata_i;
        mem_re_o    = 1'b1;
        mem_raddr_o = hi_q;
        state_d     = rsm_pkg::ST_SW_WR_LO;
      end
      rsm_pkg::ST_SW_WR_LO: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = lo_q;
        mem_wdata_o = mem_rdata_i;
        state_d     = rsm_pkg::ST_SW_WR_HI;
      end
      rsm_pkg::ST_SW_WR_HI: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = hi_q;
        mem_wdata_o = tmp_q;
        lo_d        = lo_n;
        hi_d        = hi_n;
        state_d     = (lo_n < hi_n) ? rsm_pkg::ST_SW_RD_LO : rsm_pkg::ST_SCAN_RD;
      end
      rsm_pkg::ST_SCAN_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = s_q;
        sc_d        = s_q;
        state_d     = rsm_pkg::ST_SCAN;
      end
      rsm_pkg::ST_SCAN: begin
        if (mem_rdata_i > mx_q) begin
          mx_d = mem_rdata_i;
        end
        if (mem_rdata_i < mn_q) begin
          mn_d = mem_rdata_i;
        end
        if (sc_q == e_q) begin
          state_d = (fill_q == '0) ? rsm_pkg::ST_SUM : rsm_pkg::ST_EMIT_RD;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = sc_q + AW'(1);
          sc_d        = sc_q + AW'(1);
        end
      end
      rsm_pkg::ST_EMIT_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = cnt_q[AW-1:0];
        pos_d       = cnt_q[AW-1:0];
        cnt_d       = cnt_q + CW'(1);
        state_d     = rsm_pkg::ST_EMIT;
      end
      rsm_pkg::ST_EMIT: begin
        // The read data holds until the word is loaded and the next read goes out.
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d          = '0;
          out_d.kind     = rsm_pkg::KIND_ELEM;
          out_d.position = rsm_pkg::PosW'(pos_q);
          out_d.element  = mem_rdata_i;
          if (cnt_q < fill_q) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = cnt_q[AW-1:0];
            pos_d       = cnt_q[AW-1:0];
            cnt_d       = cnt_q + CW'(1);
          end else begin
            state_d = rsm_pkg::ST_SUM;
          end
        end
      end
      rsm_pkg::ST_SUM: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d           = '0;
          out_d.kind      = rsm_pkg::KIND_SUM;
          out_d.range_max = mx_q;
          out_d.range_min = mn_q;
          out_d.last      = 1'b1;
          state_d         = rsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rsm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsm_pkg::ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    s_q   <= s_d;
    e_q   <= e_d;
    sc_q  <= sc_d;
    pos_q <= pos_d;
    tmp_q <= tmp_d;
    mx_q  <= mx_d;
    mn_q  <= mn_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re_o && mem_we_o) |-> (mem_raddr_o != mem_waddr_o))
    else $error("table read and write hit the same entry in one cycle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= depth_cnt)
    else $error("fill count exceeds table depth");

  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsm_pkg::ST_SW_RD_LO || state_q == rsm_pkg::ST_SW_RD_HI ||
     state_q == rsm_pkg::ST_SW_WR_LO || state_q == rsm_pkg::ST_SW_WR_HI)
    |-> (lo_q < hi_q))
    else $error("swap pointers crossed");

  a_sum_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsm_pkg::ST_SUM && out_free)
    |=> (state_q == rsm_pkg::ST_IDLE && out_valid_q && out_q.last))
    else $error("summary word did not end the query");
`endif

endmodule

### hdl/range_reverse_min_max_table.sv
// Range reverse / min-max table. An append returns no word unless the table is full. A query
// swaps each pair (SW_RD_LO, SW_RD_HI, SW_WR_LO, SW_WR_HI), scans the range (SCAN_RD, then
// SCAN per entry), emits the elements (EMIT_RD, then EMIT per element) and ends with the
// summary (SUM), all through the one read port of the table. One item at a time; inputs
// stall until done. Reset clears the fill count and the per-entry valid bits at once (all
// entries read as zero) and loads the floor and ceiling with 0 and 1000.
module range_reverse_min_max_table #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [rsm_pkg::ValW-1:0]        cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rsm_pkg::in_word_t               in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rsm_pkg::out_word_t              out_word_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rsm_pkg::cfg_t cfg_q;

  logic                            mem_re;
  logic [AW-1:0]                   mem_raddr;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic signed [rsm_pkg::ValW-1:0] mem_wdata;
  logic signed [rsm_pkg::ValW-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_floor   <= rsm_pkg::MAX_FLOOR_RST;
      cfg_q.min_ceiling <= rsm_pkg::MIN_CEILING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsm_pkg::CFG_MAX_FLOOR:   cfg_q.max_floor   <= cfg_data_i;
        rsm_pkg::CFG_MIN_CEILING: cfg_q.min_ceiling <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rsm_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  rsm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule
